// ===== hw/rtl/mdrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mdrc_pkg
// Shared types, constants and helper function of the mesh distance and
// region count block.
// ----------------------------------------------------------------------------
package mdrc_pkg;

    localparam int NODES_DEF = 64;
    localparam int QDEPTH_DEF = 2;

    localparam int KIND_W = 2;
    localparam int CORE_W = 6;
    localparam int NODE_W = 6;
    localparam int DIM_W = 7;
    localparam int RAD_W = 7;
    localparam int ANS_W = 7;
    localparam int ROW_W = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REGION = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] GRID_WIDTH_RST = 7'd6;
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 7'd8;

    localparam logic [ANS_W-1:0] ANS_MAX = 7'd127;

    typedef struct packed {
        logic              region;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [RAD_W-1:0]  radius;
    } job_t;

    // nodes of one diamond row with half-width l around column x
    function automatic logic [ROW_W-1:0] row_nodes(
        input logic [NODE_W-1:0] x,
        input logic [RAD_W-1:0]  l,
        input logic [DIM_W-1:0]  w
    );
        logic [DIM_W:0]   xl;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] left;
        xl = {2'b00, x} + {1'b0, l};
        if (xl < {1'b0, w})
            right = l;
        else
            right = w - 7'd1 - {1'b0, x};
        if (l <= {1'b0, x})
            left = l;
        else
            left = {1'b0, x};
        return ROW_W'(1) + ROW_W'(right) + ROW_W'(left);
    endfunction

endpackage

// ===== hw/rtl/mesh_distance_and_region_count.sv =====
// ----------------------------------------------------------------------------
// mesh_distance_and_region_count
// Core-to-grid map with Manhattan distance and diamond region count queries.
//
//   channel   handshake               payload
//   input     push / full             kind, core_a, core_b, grid_index, radius
//   result    empty / pop             answer
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a load gives no result
// a distance query passes through lookup, 6 divide steps by the grid
// width, evaluation and hand-off to the result queue
// a region query also walks the diamond rows, up to 2 * radius + 1
// jobs and answers are queued two deep each; full rises while the lookup stage
// and the job queue are both taken, and reset empties both queues
// ----------------------------------------------------------------------------
module mesh_distance_and_region_count #(
    parameter int NODES = mdrc_pkg::NODES_DEF,
    parameter int QDEPTH = mdrc_pkg::QDEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [mdrc_pkg::KIND_W-1:0]     kind,
    input  logic [mdrc_pkg::CORE_W-1:0]     core_a,
    input  logic [mdrc_pkg::CORE_W-1:0]     core_b,
    input  logic [mdrc_pkg::NODE_W-1:0]     grid_index,
    input  logic [mdrc_pkg::RAD_W-1:0]      radius,
    output logic                            empty,
    input  logic                            pop,
    output logic [mdrc_pkg::ANS_W-1:0]      answer,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mdrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdrc_pkg::DIM_W-1:0]      cfg_data
);
    import mdrc_pkg::*;

    localparam int JOB_W = $bits(job_t);

    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_width_next;
    logic [DIM_W-1:0] grid_height_reg;
    logic [DIM_W-1:0] grid_height_next;
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;

    logic             fq_push;
    logic             fq_full;
    job_t             fq_wdata;
    logic             fq_pop;
    logic             fq_empty;
    logic [JOB_W-1:0] fq_rdata;
    logic             rq_push;
    logic             rq_full;
    logic [ANS_W-1:0] rq_wdata;

    assign cfg_ready = 1'b1;
    assign eff_width = (grid_width_reg == '0) ? DIM_W'(1) : grid_width_reg;
    assign eff_height = (grid_height_reg == '0) ? DIM_W'(1) : grid_height_reg;

    always_comb
    begin
        grid_width_next = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_next = cfg_data;
                REG_GRID_HEIGHT: grid_height_next = cfg_data;
                default:
                begin
                    grid_width_next = grid_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end
        else
        begin
            grid_width_reg <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    mdrc_front #(
        .NODES(NODES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .core_a(core_a),
        .core_b(core_b),
        .grid_index(grid_index),
        .radius(radius),
        .q_push(fq_push),
        .q_full(fq_full),
        .q_data(fq_wdata)
    );

    mdrc_fifo #(
        .W(JOB_W),
        .DEPTH(QDEPTH)
    ) u_job_q (
        .clk(clk),
        .rst_n(rst_n),
        .push(fq_push),
        .full(fq_full),
        .wdata(fq_wdata),
        .pop(fq_pop),
        .empty(fq_empty),
        .rdata(fq_rdata)
    );

    mdrc_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .eff_width(eff_width),
        .eff_height(eff_height),
        .job_empty(fq_empty),
        .job_pop(fq_pop),
        .job(job_t'(fq_rdata)),
        .res_push(rq_push),
        .res_full(rq_full),
        .res_data(rq_wdata)
    );

    mdrc_fifo #(
        .W(ANS_W),
        .DEPTH(QDEPTH)
    ) u_res_q (
        .clk(clk),
        .rst_n(rst_n),
        .push(rq_push),
        .full(rq_full),
        .wdata(rq_wdata),
        .pop(pop),
        .empty(empty),
        .rdata(answer)
    );

endmodule

// ===== hw/rtl/mdrc_fifo.sv =====
// ----------------------------------------------------------------------------
// mdrc_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mdrc_fifo #(
    parameter int W = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/mdrc_front.sv =====
// ----------------------------------------------------------------------------
// mdrc_front
// Accepts items, writes map entries on loads and looks up the grid nodes
// of queries, handing each query on as a job.
// ----------------------------------------------------------------------------
module mdrc_front #(
    parameter int NODES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mdrc_pkg::KIND_W-1:0]   kind,
    input  logic [mdrc_pkg::CORE_W-1:0]   core_a,
    input  logic [mdrc_pkg::CORE_W-1:0]   core_b,
    input  logic [mdrc_pkg::NODE_W-1:0]   grid_index,
    input  logic [mdrc_pkg::RAD_W-1:0]    radius,
    output logic                          q_push,
    input  logic                          q_full,
    output mdrc_pkg::job_t                q_data
);
    import mdrc_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int EXT_W = (AW > CORE_W) ? AW : CORE_W;

    logic [NODE_W-1:0] map_store [NODES];

    logic [EXT_W-1:0]  ext_a;
    logic [EXT_W-1:0]  ext_b;
    logic [AW-1:0]     idx_a;
    logic [AW-1:0]     idx_b;
    logic              rng_a;
    logic              rng_b;
    logic              accept;
    logic              accept_query;
    logic              stg_valid_reg;
    logic              stg_valid_next;
    logic              stg_region_reg;
    logic              stg_rng_a_reg;
    logic              stg_rng_b_reg;
    logic [RAD_W-1:0]  stg_radius_reg;
    logic [NODE_W-1:0] rd_a_reg;
    logic [NODE_W-1:0] rd_b_reg;

    assign ext_a = EXT_W'(core_a);
    assign ext_b = EXT_W'(core_b);
    assign idx_a = ext_a[AW-1:0];
    assign idx_b = ext_b[AW-1:0];
    assign rng_a = (32'(core_a) < NODES);
    assign rng_b = (32'(core_b) < NODES);

    assign full = stg_valid_reg && q_full;
    assign accept = push && !full;
    assign accept_query = accept && ((kind == KIND_DIST) || (kind == KIND_REGION));

    assign q_push = stg_valid_reg;
    assign q_data.region = stg_region_reg;
    assign q_data.node_a = stg_rng_a_reg ? rd_a_reg : '0;
    assign q_data.node_b = stg_rng_b_reg ? rd_b_reg : '0;
    assign q_data.radius = stg_radius_reg;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (accept_query)
        begin
            stg_valid_next = 1'b1;
        end
        else if (stg_valid_reg && !q_full)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // map store write and lookup
    always_ff @(posedge clk)
    begin
        if (accept && (kind == KIND_LOAD) && rng_a)
        begin
            map_store[idx_a] <= grid_index;
        end
        if (accept_query)
        begin
            rd_a_reg <= map_store[idx_a];
            rd_b_reg <= map_store[idx_b];
            stg_region_reg <= (kind == KIND_REGION);
            stg_rng_a_reg <= rng_a;
            stg_rng_b_reg <= rng_b;
            stg_radius_reg <= radius;
        end
    end

    a_load_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_LOAD) && !stg_valid_reg) |=> !stg_valid_reg)
        else $error("load transaction produced a job");

    a_query_job: assert property (@(posedge clk) disable iff (!rst_n)
        accept_query |=> stg_valid_reg)
        else $error("query transaction lost in front stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && q_full) |=> stg_valid_reg)
        else $error("stalled job dropped");

endmodule

// ===== hw/rtl/mdrc_back.sv =====
// ----------------------------------------------------------------------------
// mdrc_back
// Executes jobs: divides node indexes by the grid width, then forms the
// distance or walks the diamond rows down and up to count its nodes.
// ----------------------------------------------------------------------------
module mdrc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mdrc_pkg::DIM_W-1:0]  eff_width,
    input  logic [mdrc_pkg::DIM_W-1:0]  eff_height,
    input  logic                        job_empty,
    output logic                        job_pop,
    input  mdrc_pkg::job_t              job,
    output logic                        res_push,
    input  logic                        res_full,
    output logic [mdrc_pkg::ANS_W-1:0]  res_data
);
    import mdrc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_DOWN = 3'd3;
    localparam logic [2:0] ST_UP = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    localparam logic [2:0] DIV_LAST = 3'(NODE_W - 1);

    logic [2:0]        st_reg;
    logic [2:0]        st_next;
    logic [2:0]        cnt_reg;
    logic [2:0]        cnt_next;
    logic [NODE_W-1:0] dvd_a_reg;
    logic [NODE_W-1:0] dvd_a_next;
    logic [NODE_W-1:0] dvd_b_reg;
    logic [NODE_W-1:0] dvd_b_next;
    logic [NODE_W-1:0] rem_a_reg;
    logic [NODE_W-1:0] rem_a_next;
    logic [NODE_W-1:0] rem_b_reg;
    logic [NODE_W-1:0] rem_b_next;
    logic              region_reg;
    logic              region_next;
    logic [RAD_W-1:0]  radius_reg;
    logic [RAD_W-1:0]  radius_next;
    logic [RAD_W-1:0]  lvl_reg;
    logic [RAD_W-1:0]  lvl_next;
    logic [NODE_W-1:0] dnl_reg;
    logic [NODE_W-1:0] dnl_next;
    logic [DIM_W-1:0]  row_reg;
    logic [DIM_W-1:0]  row_next;
    logic [ANS_W-1:0]  ans_reg;
    logic [ANS_W-1:0]  ans_next;

    logic [NODE_W:0]   ta;
    logic [NODE_W:0]   tb;
    logic              ge_a;
    logic              ge_b;
    logic [NODE_W-1:0] dx;
    logic [NODE_W-1:0] dy;
    logic [ROW_W-1:0]  row_cnt;
    logic [ROW_W:0]    acc;
    logic [ANS_W-1:0]  acc_sat;

    assign ta = {rem_a_reg, dvd_a_reg[NODE_W-1]};
    assign tb = {rem_b_reg, dvd_b_reg[NODE_W-1]};
    assign ge_a = (ta >= eff_width);
    assign ge_b = (tb >= eff_width);

    // after the divide: dvd holds the row, rem the column
    assign dx = (rem_a_reg > rem_b_reg) ? rem_a_reg - rem_b_reg : rem_b_reg - rem_a_reg;
    assign dy = (dvd_a_reg > dvd_b_reg) ? dvd_a_reg - dvd_b_reg : dvd_b_reg - dvd_a_reg;

    assign row_cnt = row_nodes(rem_a_reg, lvl_reg, eff_width);
    assign acc = (ROW_W + 1)'(ans_reg) + (ROW_W + 1)'(row_cnt);
    assign acc_sat = (acc > (ROW_W + 1)'(ANS_MAX)) ? ANS_MAX : acc[ANS_W-1:0];

    assign job_pop = (st_reg == ST_IDLE) && !job_empty;
    assign res_push = (st_reg == ST_DONE);
    assign res_data = ans_reg;

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        dvd_a_next = dvd_a_reg;
        dvd_b_next = dvd_b_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        region_next = region_reg;
        radius_next = radius_reg;
        lvl_next = lvl_reg;
        dnl_next = dnl_reg;
        row_next = row_reg;
        ans_next = ans_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    dvd_a_next = job.node_a;
                    dvd_b_next = job.node_b;
                    rem_a_next = '0;
                    rem_b_next = '0;
                    region_next = job.region;
                    radius_next = job.radius;
                    cnt_next = '0;
                    st_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_a_next = ge_a ? NODE_W'(ta - NODE_W'(0) - eff_width) : ta[NODE_W-1:0];
                rem_b_next = ge_b ? NODE_W'(tb - NODE_W'(0) - eff_width) : tb[NODE_W-1:0];
                dvd_a_next = {dvd_a_reg[NODE_W-2:0], ge_a};
                dvd_b_next = {dvd_b_reg[NODE_W-2:0], ge_b};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    st_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (region_reg)
                begin
                    lvl_next = radius_reg;
                    dnl_next = dvd_a_reg;
                    row_next = DIM_W'(dvd_a_reg) + DIM_W'(1);
                    ans_next = '0;
                    st_next = ST_DOWN;
                end
                else
                begin
                    ans_next = ANS_W'(dx) + ANS_W'(dy);
                    st_next = ST_DONE;
                end
            end
            ST_DOWN:
            begin
                ans_next = acc_sat;
                if ((lvl_reg == '0) || (dnl_reg == '0))
                begin
                    if (radius_reg == '0)
                    begin
                        st_next = ST_DONE;
                    end
                    else
                    begin
                        lvl_next = radius_reg - RAD_W'(1);
                        st_next = ST_UP;
                    end
                end
                else
                begin
                    lvl_next = lvl_reg - RAD_W'(1);
                    dnl_next = dnl_reg - NODE_W'(1);
                end
            end
            ST_UP:
            begin
                if (row_reg >= eff_height)
                begin
                    st_next = ST_DONE;
                end
                else
                begin
                    ans_next = acc_sat;
                    if (lvl_reg == '0)
                    begin
                        st_next = ST_DONE;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - RAD_W'(1);
                        row_next = row_reg + DIM_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!res_full)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_a_reg <= dvd_a_next;
        dvd_b_reg <= dvd_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        region_reg <= region_next;
        radius_reg <= radius_next;
        lvl_reg <= lvl_next;
        dnl_reg <= dnl_next;
        row_reg <= row_next;
        ans_reg <= ans_next;
    end

    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (st_reg == ST_DIV) && (cnt_reg == '0))
        else $error("job taken without starting the divide");

    a_done_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res_full) |=> (st_reg == ST_IDLE))
        else $error("result transaction did not end the job");

    a_up_above: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_UP) |-> (row_reg > DIM_W'(dvd_a_reg)))
        else $error("upward walk below centre row");

endmodule

// ===== tb/mesh_distance_and_region_count_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_distance_and_region_count_test
// Self-checking testbench of the mesh distance and region count block. A
// scoreboard keeps its own core-to-node table and grid size, predicts the
// answer of every accepted distance and region query and compares it with
// the answers popped from the block. Directed items hit the grid edges,
// nodes past the last grid row, radii far past the grid and the unused kind;
// random items then run under several grid sizes and idling patterns on both sides.
// ----------------------------------------------------------------------------
module mesh_distance_and_region_count_test;
    import mdrc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 300;
    localparam int SEGMENTS = 8;
    localparam int SEGMENT_ITEMS = 190;
    localparam int unsigned SEG_WIDTH [SEGMENTS] = '{6, 1, 64, 0, 127, 3, 13, 0};
    localparam int unsigned SEG_HEIGHT [SEGMENTS] = '{8, 64, 1, 0, 127, 21, 5, 0};

    class mesh_scoreboard;
        bit [NODE_W-1:0] node_tab [NODES_DEF];
        int unsigned width_reg = GRID_WIDTH_RST;
        int unsigned height_reg = GRID_HEIGHT_RST;
        logic [ANS_W-1:0] answers_due [$];
        int errors = 0;

        function int unsigned dim_or_one(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function int unsigned row_span(int unsigned x, int unsigned l, int unsigned w);
            int unsigned right;
            int unsigned left;
            right = (x + l < w) ? l : w - 1 - x;
            left = (l <= x) ? l : x;
            return 1 + right + left;
        endfunction

        function int unsigned hop_distance(logic [CORE_W-1:0] a, logic [CORE_W-1:0] b);
            int unsigned w;
            int unsigned x1, y1, x2, y2;
            w = dim_or_one(width_reg);
            x1 = node_tab[a] % w;
            y1 = node_tab[a] / w;
            x2 = node_tab[b] % w;
            y2 = node_tab[b] / w;
            return ((x1 > x2) ? x1 - x2 : x2 - x1) + ((y1 > y2) ? y1 - y2 : y2 - y1);
        endfunction

        function int unsigned region_size(logic [CORE_W-1:0] c, int unsigned r);
            int unsigned w, h, x, y0, total, k;
            w = dim_or_one(width_reg);
            h = dim_or_one(height_reg);
            x = node_tab[c] % w;
            y0 = node_tab[c] / w;
            total = 0;
            // centre row and the rows below it
            for (k = 0; k <= r && k <= y0; k++)
                total += row_span(x, r - k, w);
            // rows above the centre, clipped at the grid height
            if (r >= 1)
            begin
                for (k = 0; k <= r - 1 && y0 + 1 + k < h; k++)
                    total += row_span(x, r - 1 - k, w);
            end
            return (total > ANS_MAX) ? ANS_MAX : total;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            if (idx == REG_GRID_WIDTH)
                width_reg = val;
            else
                height_reg = val;
        endfunction

        function void note_input(logic [KIND_W-1:0] k, logic [CORE_W-1:0] a,
                                 logic [CORE_W-1:0] b, logic [NODE_W-1:0] g,
                                 logic [RAD_W-1:0] r);
            case (k)
                KIND_LOAD: node_tab[a] = g;
                KIND_DIST: answers_due.push_back(ANS_W'(hop_distance(a, b)));
                KIND_REGION: answers_due.push_back(ANS_W'(region_size(a, r)));
                default: ;
            endcase
        endfunction

        function void check_result(logic [ANS_W-1:0] got);
            logic [ANS_W-1:0] want;
            if (answers_due.size() == 0)
            begin
                $display("%0t: unexpected answer %0d, expected none", $time, got);
                errors++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (want !== got)
                begin
                    $display("%0t: answer mismatch, expected %0d, got %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [KIND_W-1:0]    kind;
    logic [CORE_W-1:0]    core_a;
    logic [CORE_W-1:0]    core_b;
    logic [NODE_W-1:0]    grid_index;
    logic [RAD_W-1:0]     radius;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [ANS_W-1:0]     answer;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    mesh_scoreboard sb = new();
    bit written [NODES_DEF];
    int send_idle = 0;
    int recv_stall = 0;

    mesh_distance_and_region_count i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .core_a     (core_a),
        .core_b     (core_b),
        .grid_index (grid_index),
        .radius     (radius),
        .empty      (empty),
        .pop        (pop),
        .answer     (answer),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(answer);
        pop <= rst_n && ($urandom_range(99) >= recv_stall);
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [CORE_W-1:0] a,
                             input logic [CORE_W-1:0] b, input logic [NODE_W-1:0] g,
                             input logic [RAD_W-1:0] r);
        push <= 1'b1;
        kind <= k;
        core_a <= a;
        core_b <= b;
        grid_index <= g;
        radius <= r;
        do @(posedge clk); while (full);
        sb.note_input(k, a, b, g, r);
        if (k == KIND_LOAD)
            written[a] = 1'b1;
        if ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int count;
        int pick;
        int rp;
        logic [KIND_W-1:0] k;
        logic [CORE_W-1:0] ca;
        logic [CORE_W-1:0] cb;
        logic [NODE_W-1:0] gi;
        logic [RAD_W-1:0] rad;

        rst_n <= 1'b0;
        push <= 1'b0;
        kind <= KIND_LOAD;
        core_a <= '0;
        core_b <= '0;
        grid_index <= '0;
        radius <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset grid of 6 by 8
        send_item(KIND_LOAD, 0, 63, 0, 127);
        send_item(KIND_LOAD, 63, 0, 63, 0);
        send_item(KIND_LOAD, 5, 21, 47, 85);
        send_item(KIND_LOAD, 1, 42, 42, 42);
        send_item(KIND_LOAD, 2, 2, 21, 7);
        send_item(KIND_DIST, 0, 63, 0, 0);
        send_item(KIND_DIST, 63, 0, 63, 127);
        send_item(KIND_DIST, 5, 5, 0, 0);
        send_item(KIND_DIST, 0, 1, 63, 1);
        send_item(KIND_DIST, 2, 5, 21, 64);
        send_item(KIND_REGION, 0, 0, 0, 0);
        send_item(KIND_REGION, 0, 63, 63, 1);
        // centre on the right edge
        send_item(KIND_REGION, 5, 0, 0, 3);
        // centre past the last grid row
        send_item(KIND_REGION, 63, 0, 0, 2);
        // radius far past the grid edges
        send_item(KIND_REGION, 63, 63, 63, 127);
        send_item(KIND_REGION, 2, 1, 5, 7);
        send_item(KIND_REGION, 1, 0, 0, 127);
        send_item(KIND_SPARE, 63, 63, 63, 127);
        send_item(KIND_SPARE, 0, 0, 0, 0);
        send_item(KIND_LOAD, 5, 0, 0, 0);
        send_item(KIND_DIST, 5, 63, 0, 0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            if (seg == SEGMENTS - 1)
            begin
                write_reg(REG_GRID_WIDTH, DIM_W'($urandom_range(127)));
                write_reg(REG_GRID_HEIGHT, DIM_W'($urandom_range(127)));
            end
            else if (seg != 0)
            begin
                write_reg(REG_GRID_WIDTH, DIM_W'(SEG_WIDTH[seg]));
                write_reg(REG_GRID_HEIGHT, DIM_W'(SEG_HEIGHT[seg]));
            end
            case (seg % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 69; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 69; end
                default: begin send_idle = 8; recv_stall = 8; end
            endcase

            count = 0;
            while (count < SEGMENT_ITEMS)
            begin
                if (seg == 2 && count == SEGMENT_ITEMS / 2)
                    drain();
                pick = $urandom_range(99);
                rp = $urandom_range(99);
                ca = CORE_W'($urandom);
                cb = CORE_W'($urandom);
                gi = NODE_W'($urandom);
                if (rp < 90)
                    rad = RAD_W'($urandom_range(15));
                else if (rp < 97)
                    rad = RAD_W'($urandom_range(63, 16));
                else
                    rad = RAD_W'($urandom_range(127, 64));
                if (pick < 3)
                    k = KIND_SPARE;
                else if (pick < 28)
                    k = KIND_LOAD;
                else
                begin
                    k = (pick < 64) ? KIND_DIST : KIND_REGION;
                    // never query a table entry that has not been loaded
                    if (!written[ca] || (k == KIND_DIST && !written[cb]))
                        k = KIND_LOAD;
                end
                send_item(k, ca, cb, gi, rad);
                if (k != KIND_SPARE)
                    count++;
            end
        end

        drain();
        if (sb.errors == 0 && sb.answers_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
